// ===== sv/ata_pkg.sv =====
package ata_pkg;

  localparam int CORDIC_ITERATIONS_DEF = 16;
  localparam int ACCEL_WIDTH_DEF = 16;

  localparam int TABLE_LEN = 24;
  localparam int ROOT_STEPS = 32;
  localparam int DIV_STEPS = 32;
  localparam int STEP_W = 6;
  localparam int IDX_W = 5;

  localparam int ACCEL_PORT_W = 16;
  localparam int EXT_W = 25;
  localparam int ANGLE_W = 15;
  localparam int COUNT_W = 16;
  localparam int SUM_W = 32;
  localparam int VEC_W = 36;
  localparam int ACC_W = 25;

  localparam logic signed [16:0] ANGLE_LIMIT = 17'sd11520;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_AVERAGE = 1'b1;

  typedef struct packed {
    logic             load;
    logic             sq_a;
    logic             sq_b;
    logic             sq_c;
    logic             root_step;
    logic             rot_init;
    logic             rot_step;
    logic             ang_store;
    logic             div_init;
    logic             div_step;
    logic             div_store;
    logic             out_load;
    logic             avg;
    logic             pass;
    logic [IDX_W-1:0] idx;
  } cmd_t;

  typedef struct packed {
    logic count_zero;
  } status_t;

  // atan(2^-i) in degrees, 16 fraction bits
  function automatic logic [21:0] atan_tab(input logic [IDX_W-1:0] i);
    logic [21:0] v;
    unique case (i)
      5'd0:  v = 22'd2949120;
      5'd1:  v = 22'd1740967;
      5'd2:  v = 22'd919879;
      5'd3:  v = 22'd466945;
      5'd4:  v = 22'd234379;
      5'd5:  v = 22'd117304;
      5'd6:  v = 22'd58666;
      5'd7:  v = 22'd29335;
      5'd8:  v = 22'd14668;
      5'd9:  v = 22'd7334;
      5'd10: v = 22'd3667;
      5'd11: v = 22'd1833;
      5'd12: v = 22'd917;
      5'd13: v = 22'd458;
      5'd14: v = 22'd229;
      5'd15: v = 22'd115;
      5'd16: v = 22'd57;
      5'd17: v = 22'd29;
      5'd18: v = 22'd14;
      5'd19: v = 22'd7;
      5'd20: v = 22'd4;
      5'd21: v = 22'd2;
      5'd22: v = 22'd1;
      default: v = 22'd0;
    endcase
    return v;
  endfunction

endpackage

// ===== sv/ata_in_if.sv =====
interface ata_in_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic [15:0] accel_x;
  logic [15:0] accel_y;
  logic [15:0] accel_z;

  modport source(output valid, operation, accel_x, accel_y, accel_z, input ready);
  modport sink(input valid, operation, accel_x, accel_y, accel_z, output ready);
endinterface

// ===== sv/ata_out_if.sv =====
interface ata_out_if;
  logic        valid;
  logic        ready;
  logic [14:0] pitch_angle;
  logic [14:0] roll_angle;
  logic [15:0] sample_count;
  logic        is_average;
  logic        empty_average;

  modport source(output valid, pitch_angle, roll_angle, sample_count, is_average,
                 empty_average, input ready);
  modport sink(input valid, pitch_angle, roll_angle, sample_count, is_average,
               empty_average, output ready);
endinterface

// ===== sv/ata_ctrl.sv =====
module ata_ctrl #(
  parameter int CORDIC_ITERATIONS = ata_pkg::CORDIC_ITERATIONS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic             in_op,
  output logic             in_ready,
  input  logic             out_ready,
  output logic             out_valid,
  input  ata_pkg::status_t status,
  output ata_pkg::cmd_t    cmd
);
  import ata_pkg::*;

  localparam int ROT_STEPS = (CORDIC_ITERATIONS > TABLE_LEN) ? TABLE_LEN : CORDIC_ITERATIONS;

  typedef enum logic [3:0] {
    S_IDLE, S_SQ_A, S_SQ_B, S_SQ_C, S_ROOT, S_ROT_INIT, S_ROT, S_ANG,
    S_DIV_INIT, S_DIV, S_DIV_END, S_DONE
  } state_t;

  state_t            state;
  logic [STEP_W-1:0] step;
  logic              pass;
  logic              is_avg;
  logic              out_free;

  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd = '0;
    cmd.load      = (state == S_IDLE) && in_valid;
    cmd.sq_a      = (state == S_SQ_A);
    cmd.sq_b      = (state == S_SQ_B);
    cmd.sq_c      = (state == S_SQ_C);
    cmd.root_step = (state == S_ROOT);
    cmd.rot_init  = (state == S_ROT_INIT);
    cmd.rot_step  = (state == S_ROT);
    cmd.ang_store = (state == S_ANG);
    cmd.div_init  = (state == S_DIV_INIT);
    cmd.div_step  = (state == S_DIV);
    cmd.div_store = (state == S_DIV_END);
    cmd.out_load  = (state == S_DONE) && out_free;
    cmd.avg       = is_avg;
    cmd.pass      = pass;
    cmd.idx       = step[IDX_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      step      <= '0;
      pass      <= 1'b0;
      is_avg    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          step <= '0;
          pass <= 1'b0;
          if (in_valid) begin
            is_avg <= in_op;
            if (in_op == OP_SAMPLE) begin
              state <= S_SQ_A;
            end else if (status.count_zero) begin
              state <= S_DONE;
            end else begin
              state <= S_DIV_INIT;
            end
          end
        end
        S_SQ_A: state <= S_SQ_B;
        S_SQ_B: state <= S_SQ_C;
        S_SQ_C: begin
          step  <= '0;
          state <= S_ROOT;
        end
        S_ROOT: begin
          if (step == STEP_W'(ROOT_STEPS - 1)) begin
            step  <= '0;
            state <= S_ROT_INIT;
          end else begin
            step <= step + 1'b1;
          end
        end
        S_ROT_INIT: state <= S_ROT;
        S_ROT: begin
          if (step == STEP_W'(ROT_STEPS - 1)) begin
            step  <= '0;
            state <= S_ANG;
          end else begin
            step <= step + 1'b1;
          end
        end
        S_ANG: begin
          if (pass) begin
            state <= S_DONE;
          end else begin
            pass  <= 1'b1;
            state <= S_SQ_A;
          end
        end
        S_DIV_INIT: begin
          step  <= '0;
          state <= S_DIV;
        end
        S_DIV: begin
          if (step == STEP_W'(DIV_STEPS - 1)) begin
            step  <= '0;
            state <= S_DIV_END;
          end else begin
            step <= step + 1'b1;
          end
        end
        S_DIV_END: begin
          if (pass) begin
            state <= S_DONE;
          end else begin
            pass  <= 1'b1;
            state <= S_DIV_INIT;
          end
        end
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== sv/ata_dp.sv =====
module ata_dp #(
  parameter int ACCEL_WIDTH = ata_pkg::ACCEL_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  ata_pkg::cmd_t       cmd,
  output ata_pkg::status_t    status,
  input  logic [15:0]         accel_x,
  input  logic [15:0]         accel_y,
  input  logic [15:0]         accel_z,
  output logic signed [14:0]  pitch_angle,
  output logic signed [14:0]  roll_angle,
  output logic [15:0]         sample_count,
  output logic                is_average,
  output logic                empty_average
);
  import ata_pkg::*;

  localparam logic [EXT_W-1:0] EXT_MASK = EXT_W'((64'd1 << ACCEL_WIDTH) - 64'd1);

  logic signed [EXT_W-1:0]   x, y, z;
  logic signed [EXT_W-1:0]   num, mul_op;
  logic signed [49:0]        sq_full;
  logic [46:0]               prod;
  logic [47:0]               sq;
  logic [63:0]               rad;
  logic [34:0]               rem, rem_t, trial;
  logic [31:0]               root;
  logic signed [VEC_W-1:0]   xv, yv, dx, dy;
  logic signed [ACC_W-1:0]   acc, tab;
  logic                      zero_vec;
  logic signed [25:0]        acc_rnd;
  logic signed [16:0]        ang_raw;
  logic signed [ANGLE_W-1:0] ang;
  logic signed [ANGLE_W-1:0] pitch_a, roll_a, pitch_v, roll_v;
  logic signed [SUM_W-1:0]   pitch_sum, roll_sum, sum_sel;
  logic [SUM_W-1:0]          mag;
  logic [COUNT_W-1:0]        count;
  logic [SUM_W-1:0]          div_d;
  logic [COUNT_W-1:0]        div_r;
  logic [COUNT_W:0]          div_t;
  logic                      div_ge, div_neg;
  logic [ANGLE_W-1:0]        quo;

  function automatic logic signed [EXT_W-1:0] sext(input logic [15:0] v);
    logic [EXT_W-1:0] raw;
    raw = {{(EXT_W-16){1'b0}}, v};
    return raw[ACCEL_WIDTH-1] ? (raw | ~EXT_MASK) : (raw & EXT_MASK);
  endfunction

  assign status.count_zero = (count == '0);

  // pass 0 is pitch: angle of x against |(y, z)|; pass 1 is roll
  assign num     = cmd.pass ? y : x;
  assign mul_op  = cmd.sq_a ? (cmd.pass ? x : y) : z;
  assign sq_full = mul_op * mul_op;

  assign rem_t = {rem[32:0], rad[63:62]};
  assign trial = {1'b0, root, 2'b01};

  assign dx  = yv >>> cmd.idx;
  assign dy  = xv >>> cmd.idx;
  assign tab = ACC_W'(atan_tab(cmd.idx));

  assign acc_rnd = {acc[ACC_W-1], acc} + 26'sd256;
  assign ang_raw = 17'(acc_rnd >>> 9);
  always_comb begin
    priority if (zero_vec) begin
      ang = '0;
    end else if (ang_raw > ANGLE_LIMIT) begin
      ang = ANGLE_W'(ANGLE_LIMIT);
    end else if (ang_raw < -ANGLE_LIMIT) begin
      ang = ANGLE_W'(-ANGLE_LIMIT);
    end else begin
      ang = ang_raw[ANGLE_W-1:0];
    end
  end

  assign sum_sel = cmd.pass ? roll_sum : pitch_sum;
  assign mag     = sum_sel[SUM_W-1] ? SUM_W'(-sum_sel) : SUM_W'(sum_sel);
  assign div_t   = {div_r, div_d[SUM_W-1]};
  assign div_ge  = div_t >= {1'b0, count};
  assign quo     = div_d[ANGLE_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x <= sext(accel_x);
      y <= sext(accel_y);
      z <= sext(accel_z);
    end
    if (cmd.sq_a) begin
      prod <= sq_full[46:0];
    end
    if (cmd.sq_b) begin
      sq   <= {1'b0, prod};
      prod <= sq_full[46:0];
    end
    if (cmd.sq_c) begin
      rad  <= {48'(sq + {1'b0, prod}), 16'd0};
      rem  <= '0;
      root <= '0;
    end
    if (cmd.root_step) begin
      rad <= {rad[61:0], 2'b00};
      if (rem_t >= trial) begin
        rem  <= rem_t - trial;
        root <= {root[30:0], 1'b1};
      end else begin
        rem  <= rem_t;
        root <= {root[30:0], 1'b0};
      end
    end
    if (cmd.rot_init) begin
      xv       <= VEC_W'({4'd0, root});
      yv       <= VEC_W'(num) <<< 8;
      acc      <= '0;
      zero_vec <= (root == '0) && (num == '0);
    end
    if (cmd.rot_step) begin
      if (yv < 0) begin
        xv  <= xv - dx;
        yv  <= yv + dy;
        acc <= acc - tab;
      end else begin
        xv  <= xv + dx;
        yv  <= yv - dy;
        acc <= acc + tab;
      end
    end
    if (cmd.ang_store) begin
      if (cmd.pass) begin
        roll_a <= ang;
      end else begin
        pitch_a <= ang;
      end
    end
    if (cmd.div_init) begin
      div_d   <= SUM_W'(mag + {{(SUM_W-COUNT_W+1){1'b0}}, count[COUNT_W-1:1]});
      div_r   <= '0;
      div_neg <= sum_sel[SUM_W-1];
    end
    if (cmd.div_step) begin
      div_d <= {div_d[SUM_W-2:0], div_ge};
      div_r <= div_ge ? COUNT_W'(div_t - {1'b0, count}) : div_t[COUNT_W-1:0];
    end
    if (cmd.div_store) begin
      if (cmd.pass) begin
        roll_v <= div_neg ? ANGLE_W'(-quo) : ANGLE_W'(quo);
      end else begin
        pitch_v <= div_neg ? ANGLE_W'(-quo) : ANGLE_W'(quo);
      end
    end
    if (cmd.out_load) begin
      is_average <= cmd.avg;
      if (cmd.avg) begin
        empty_average <= (count == '0);
        pitch_angle   <= (count == '0) ? '0 : pitch_v;
        roll_angle    <= (count == '0) ? '0 : roll_v;
        sample_count  <= count;
      end else begin
        empty_average <= 1'b0;
        pitch_angle   <= pitch_a;
        roll_angle    <= roll_a;
        sample_count  <= (count == COUNT_MAX) ? count : count + 1'b1;
      end
    end
  end

  // running sums and count
  always_ff @(posedge clk) begin
    if (rst) begin
      pitch_sum <= '0;
      roll_sum  <= '0;
      count     <= '0;
    end else if (cmd.out_load) begin
      if (cmd.avg) begin
        pitch_sum <= '0;
        roll_sum  <= '0;
        count     <= '0;
      end else if (count != COUNT_MAX) begin
        pitch_sum <= pitch_sum + SUM_W'(pitch_a);
        roll_sum  <= roll_sum + SUM_W'(roll_a);
        count     <= count + 1'b1;
      end
    end
  end

endmodule

// ===== sv/accel_tilt_average.sv =====
// tilt averager: each sample beat (operation 0) carries raw x, y, z acceleration and
// returns pitch = atan2(x, |(y, z)|) and roll = atan2(y, |(x, z)|) in 1/128 degree,
// both added to running sums with a saturating count (at 65535 samples are reported
// but no longer summed). an average beat (operation 1) returns sum / count rounded
// half away from zero and clears the sums; with no samples it returns zeros and
// empty_average. one item is worked at a time: a sample runs the shared bit-serial
// square root (32 steps) and CORDIC rotator once for pitch and once for roll; an
// average runs the shared restoring divider (32 steps per angle). a finished result
// sits in the output register while the next beat is already being taken.
module accel_tilt_average #(
  parameter int CORDIC_ITERATIONS = ata_pkg::CORDIC_ITERATIONS_DEF,
  parameter int ACCEL_WIDTH = ata_pkg::ACCEL_WIDTH_DEF
) (
  input  logic     clk,
  input  logic     rst,
  ata_in_if.sink   samples,
  ata_out_if.source results
);
  import ata_pkg::*;

  cmd_t    cmd;
  status_t status;

  // controller: sequences square, root, rotate and divide steps
  ata_ctrl #(
    .CORDIC_ITERATIONS(CORDIC_ITERATIONS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (samples.valid),
    .in_op     (samples.operation),
    .in_ready  (samples.ready),
    .out_ready (results.ready),
    .out_valid (results.valid),
    .status    (status),
    .cmd       (cmd)
  );

  // datapath: squares, root, cordic, divider, sums and output register
  ata_dp #(
    .ACCEL_WIDTH(ACCEL_WIDTH)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .accel_x       (samples.accel_x),
    .accel_y       (samples.accel_y),
    .accel_z       (samples.accel_z),
    .pitch_angle   (results.pitch_angle),
    .roll_angle    (results.roll_angle),
    .sample_count  (results.sample_count),
    .is_average    (results.is_average),
    .empty_average (results.empty_average)
  );

`ifndef ASSERT_OFF
  // one item in flight: after a beat is taken the input closes
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    samples.valid && samples.ready |=> !samples.ready)
    else $error("input taken while busy");

  // an empty average carries nothing but its flags
  a_empty: assert property (@(posedge clk) disable iff (rst)
    results.valid && results.empty_average |->
      results.is_average && results.pitch_angle == '0 &&
      results.roll_angle == '0 && results.sample_count == '0)
    else $error("empty average with payload");

  // a sample result always counts at least itself
  a_sample_count: assert property (@(posedge clk) disable iff (rst)
    results.valid && !results.is_average |-> results.sample_count != '0)
    else $error("sample result with zero count");

  // angles stay within +-90 degrees
  a_range: assert property (@(posedge clk) disable iff (rst)
    results.valid |->
      $signed(results.pitch_angle) <= 15'sd11520 &&
      $signed(results.pitch_angle) >= -15'sd11520 &&
      $signed(results.roll_angle) <= 15'sd11520 &&
      $signed(results.roll_angle) >= -15'sd11520)
    else $error("angle out of range");
`endif

endmodule
